### rtl/rotenc_pkg.sv
// ----------------------------------------------------------------------------
// rotenc_pkg
// shared types and constants for the rotary encoder scanner
// ----------------------------------------------------------------------------
`default_nettype none

package rotenc_pkg;

  localparam int unsigned PosW  = 8;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [PosW-1:0] PosReset = 8'd20;
  localparam logic [PosW-1:0] MinReset = 8'd0;
  localparam logic [PosW-1:0] MaxReset = 8'd40;

  // register index, taken from paddr[2]
  localparam logic RegPosMin = 1'b0;
  localparam logic RegPosMax = 1'b1;

  typedef enum logic [2:0] {
    EV_IDLE    = 3'd0,
    EV_PUSH    = 3'd1,
    EV_RELEASE = 3'd2,
    EV_CW      = 3'd3,
    EV_CCW     = 3'd4
  } event_e;

  typedef enum logic {
    MODE_SCAN = 1'b0,
    MODE_READ = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  button_level;
    logic  chan_a_level;
    logic  chan_b_level;
  } item_t;

  typedef struct packed {
    event_e            event_res;
    logic [PosW-1:0]   position;
  } result_t;

  typedef struct packed {
    logic [PosW-1:0] position_min;
    logic [PosW-1:0] position_max;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/rotenc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rotenc_cfg_regs
// apb register file holding the position limits
// ----------------------------------------------------------------------------
`default_nettype none

module rotenc_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rotenc_pkg::AddrW-1:0]    paddr,
  input  wire logic [rotenc_pkg::DataW-1:0]    pwdata,
  output logic      [rotenc_pkg::DataW-1:0]    prdata,
  output logic                                 pready,
  output rotenc_pkg::cfg_t                     cfg_o
);

  logic [rotenc_pkg::PosW-1:0] min_q, min_d;
  logic [rotenc_pkg::PosW-1:0] max_q, max_d;
  logic                        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    if (wr_en) begin
      unique case (paddr[2])
        rotenc_pkg::RegPosMin: min_d = pwdata[rotenc_pkg::PosW-1:0];
        rotenc_pkg::RegPosMax: max_d = pwdata[rotenc_pkg::PosW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= rotenc_pkg::MinReset;
      max_q <= rotenc_pkg::MaxReset;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      rotenc_pkg::RegPosMin: prdata[rotenc_pkg::PosW-1:0] = min_q;
      rotenc_pkg::RegPosMax: prdata[rotenc_pkg::PosW-1:0] = max_q;
      default: ;
    endcase
  end

  assign cfg_o.position_min = min_q;
  assign cfg_o.position_max = max_q;

endmodule

`default_nettype wire

### rtl/rotenc_core.sv
// ----------------------------------------------------------------------------
// rotenc_core
// decoder state and the per-word update logic
// ----------------------------------------------------------------------------
`default_nettype none

module rotenc_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  rotenc_pkg::item_t       item_i,
  input  rotenc_pkg::cfg_t        cfg_i,
  output rotenc_pkg::result_t     result_o
);

  logic                        started_q, started_d;
  logic                        armed_q, armed_d;
  logic                        a_prev_q, a_prev_d;
  logic [rotenc_pkg::PosW-1:0] pos_q, pos_d;
  rotenc_pkg::event_e          pend_q, pend_d;
  rotenc_pkg::event_e          ev_out;

  always_comb begin
    started_d = started_q;
    armed_d   = armed_q;
    a_prev_d  = a_prev_q;
    pos_d     = pos_q;
    pend_d    = pend_q;
    ev_out    = pend_q;
    if (item_i.mode == rotenc_pkg::MODE_READ) begin
      pend_d = rotenc_pkg::EV_IDLE;
    end else if (!started_q) begin
      // first tick only captures channel a
      started_d = 1'b1;
      a_prev_d  = item_i.chan_a_level;
    end else begin
      if (!item_i.button_level) begin
        if (armed_q) begin
          armed_d = 1'b0;
          pend_d  = rotenc_pkg::EV_PUSH;
        end
      end else if (!armed_q) begin
        armed_d = 1'b1;
        pend_d  = rotenc_pkg::EV_RELEASE;
      end
      // rotation overrides a button event
      if (item_i.chan_a_level != a_prev_q) begin
        if (item_i.chan_a_level != item_i.chan_b_level) begin
          if (pos_q < cfg_i.position_max) begin
            pos_d = pos_q + 1'b1;
          end
          pend_d = rotenc_pkg::EV_CW;
        end else begin
          if (pos_q > cfg_i.position_min) begin
            pos_d = pos_q - 1'b1;
          end
          pend_d = rotenc_pkg::EV_CCW;
        end
      end
      a_prev_d = item_i.chan_a_level;
    end
    if (item_i.mode == rotenc_pkg::MODE_SCAN) begin
      ev_out = pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      armed_q   <= 1'b1;
      a_prev_q  <= 1'b0;
      pos_q     <= rotenc_pkg::PosReset;
      pend_q    <= rotenc_pkg::EV_IDLE;
    end else if (step_i) begin
      started_q <= started_d;
      armed_q   <= armed_d;
      a_prev_q  <= a_prev_d;
      pos_q     <= pos_d;
      pend_q    <= pend_d;
    end
  end

  assign result_o.event_res = ev_out;
  assign result_o.position  = pos_d;

endmodule

`default_nettype wire

### rtl/rotenc_out_reg.sv
// ----------------------------------------------------------------------------
// rotenc_out_reg
// result register with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

module rotenc_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  rotenc_pkg::result_t     result_i,
  output logic                    can_load_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output rotenc_pkg::result_t     result_o
);

  logic                valid_q, valid_d;
  rotenc_pkg::result_t data_q;

  assign can_load_o = ~valid_q | out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

`default_nettype wire

### rtl/rotary_encoder_scanner.sv
// ----------------------------------------------------------------------------
// rotary_encoder_scanner
// quadrature decoder with push button events and a saturating position count
// ----------------------------------------------------------------------------
//
// channel   handshake                   payload
// -------   -------------------------   -------------------------------------
// in        in_valid_i / in_ready_o     mode, button, channel a and b levels
// out       out_valid_o / out_ready_i   event_res, position
// cfg       apb psel/penable/pready     position_min (0x0), position_max (0x4)
//
// an accepted word sits in the input register while the decode logic works on
// it, and its result is written to the result register as the word leaves
// one word is accepted every cycle while the output side keeps taking results
// reset clears both valid flags and loads the decoder state; no clearing pass
// a stall at the output holds the result register, then the input register,
// then drops in_ready_o; nothing is lost or repeated
//
`default_nettype none

module rotary_encoder_scanner (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic        button_level_i,
  input  wire logic        chan_a_level_i,
  input  wire logic        chan_b_level_i,

  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       event_res_o,
  output logic [7:0]       position_o,

  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  rotenc_pkg::cfg_t    cfg;
  rotenc_pkg::item_t   in_item;
  rotenc_pkg::item_t   s1_item_q;
  logic                s1_valid_q, s1_valid_d;
  logic                s1_advance;
  logic                in_fire;
  logic                out_can_load;
  rotenc_pkg::result_t core_result;
  rotenc_pkg::result_t out_result;

  rotenc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // input register: the word moves on as soon as the result register has room
  assign s1_advance = s1_valid_q & out_can_load;
  assign in_ready_o = ~s1_valid_q | s1_advance;
  assign in_fire    = in_valid_i & in_ready_o;

  assign in_item.mode         = rotenc_pkg::mode_e'(mode_i);
  assign in_item.button_level = button_level_i;
  assign in_item.chan_a_level = chan_a_level_i;
  assign in_item.chan_b_level = chan_b_level_i;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item;
    end
  end

  // decoder state updates exactly once per word, when it leaves the input register
  rotenc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_advance),
    .item_i   (s1_item_q),
    .cfg_i    (cfg),
    .result_o (core_result)
  );

  rotenc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_advance),
    .result_i    (core_result),
    .can_load_o  (out_can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign event_res_o = out_result.event_res;
  assign position_o  = out_result.position;

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for rotary_encoder_scanner
// scan and read words from a queue-fed driver; a behavioural decoder with its
// own copy of the limits predicts each result at acceptance; a monitor checks
// every result word against the oldest prediction; both sides idle at random
// and the limits are rewritten over apb between phases
// ----------------------------------------------------------------------------

module testbench;

  localparam int CycleLimit = 200000;

  // clock, reset and block ports
  logic                         clk_i          = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         in_valid_i     = 1'b0;
  logic                         in_ready_o;
  logic                         mode_i         = 1'b0;
  logic                         button_level_i = 1'b1;
  logic                         chan_a_level_i = 1'b0;
  logic                         chan_b_level_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_ready_i    = 1'b0;
  logic [2:0]                   event_res_o;
  logic [rotenc_pkg::PosW-1:0]  position_o;
  logic                         psel           = 1'b0;
  logic                         penable        = 1'b0;
  logic                         pwrite         = 1'b0;
  logic [rotenc_pkg::AddrW-1:0] paddr          = '0;
  logic [rotenc_pkg::DataW-1:0] pwdata         = '0;
  logic [rotenc_pkg::DataW-1:0] prdata;
  logic                         pready;

  // words waiting for the driver, and results still owed by the block
  rotenc_pkg::item_t   pending_words    [$];
  rotenc_pkg::result_t expected_results [$];
  rotenc_pkg::item_t   bus_word;

  // shadow decoder state and limits
  logic                        scan_started;
  logic                        btn_armed;
  logic                        a_prev;
  logic [rotenc_pkg::PosW-1:0] pos_count;
  rotenc_pkg::event_e          pend_ev;
  logic [rotenc_pkg::PosW-1:0] lim_min;
  logic [rotenc_pkg::PosW-1:0] lim_max;

  // stimulus generator state: encoder phase, turning direction, button level
  int unsigned gen_gray;
  int          gen_dir;
  logic        gen_btn;

  bit          no_idle;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned settings_used;
  int unsigned ev_seen [5];

  rotary_encoder_scanner DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .button_level_i (button_level_i),
    .chan_a_level_i (chan_a_level_i),
    .chan_b_level_i (chan_b_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_res_o    (event_res_o),
    .position_o     (position_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // run guard: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic report_mismatch(input string detail);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, detail);
  endtask

  // decoder behaviour for one accepted word; reads return the pending event and clear it
  task automatic decode_word(input rotenc_pkg::item_t w, output rotenc_pkg::result_t r);
    if (w.mode == rotenc_pkg::MODE_READ) begin
      r.event_res = pend_ev;
      pend_ev     = rotenc_pkg::EV_IDLE;
    end else begin
      if (!scan_started) begin
        // first scan after reset only latches channel a
        scan_started = 1'b1;
        a_prev       = w.chan_a_level;
      end else begin
        // button is active low and reports once per press and per release
        if (!w.button_level) begin
          if (btn_armed) begin
            btn_armed = 1'b0;
            pend_ev   = rotenc_pkg::EV_PUSH;
          end
        end else if (!btn_armed) begin
          btn_armed = 1'b1;
          pend_ev   = rotenc_pkg::EV_RELEASE;
        end
        // an edge on channel a wins over a button event in the same tick
        if (w.chan_a_level != a_prev) begin
          if (w.chan_a_level != w.chan_b_level) begin
            if (pos_count < lim_max) pos_count = pos_count + 1'b1;
            pend_ev = rotenc_pkg::EV_CW;
          end else begin
            if (pos_count > lim_min) pos_count = pos_count - 1'b1;
            pend_ev = rotenc_pkg::EV_CCW;
          end
        end
        a_prev = w.chan_a_level;
      end
      r.event_res = pend_ev;
    end
    r.position = pos_count;
  endtask

  // driver: predicts on acceptance, then offers the next word or idles
  always @(posedge clk_i) begin : drive_words
    rotenc_pkg::result_t r;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        decode_word(bus_word, r);
        expected_results.push_back(r);
        words_sent++;
      end
      if (pending_words.size() != 0 && (no_idle || $urandom_range(99) >= 36)) begin
        bus_word = pending_words.pop_front();
        mode_i         <= bus_word.mode;
        button_level_i <= bus_word.button_level;
        chan_a_level_i <= bus_word.chan_a_level;
        chan_b_level_i <= bus_word.chan_b_level;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor: every result word is matched against the oldest prediction
  always @(posedge clk_i) begin : check_results
    rotenc_pkg::result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed: event %0d position %0d",
                                    event_res_o, position_o));
        end else begin
          want = expected_results.pop_front();
          ev_seen[int'(want.event_res)]++;
          if (event_res_o !== want.event_res)
            report_mismatch($sformatf("event_res expected %0d, got %0d",
                                      want.event_res, event_res_o));
          if (position_o !== want.position)
            report_mismatch($sformatf("position expected %0d, got %0d",
                                      want.position, position_o));
        end
      end
      out_ready_i <= no_idle || ($urandom_range(99) >= 36);
    end
  end

  function automatic void queue_word(input rotenc_pkg::mode_e m, input logic btn,
                                     input logic a, input logic b);
    rotenc_pkg::item_t w;
    w.mode         = m;
    w.button_level = btn;
    w.chan_a_level = a;
    w.chan_b_level = b;
    pending_words.push_back(w);
  endfunction

  // apb write: setup cycle, then access until pready; upper data bits are junk
  task automatic write_reg(input logic idx, input logic [rotenc_pkg::PosW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom_range(32'hff_ffff, 0)), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == rotenc_pkg::RegPosMin) lim_min = val;
    else lim_max = val;
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // one phase: new limits, then reads and mostly clean quadrature walks with some noise
  task automatic run_phase(input logic [rotenc_pkg::PosW-1:0] lo,
                           input logic [rotenc_pkg::PosW-1:0] hi,
                           input int n, input bit steady);
    int unsigned pick;
    logic a, b;
    write_reg(rotenc_pkg::RegPosMin, lo);
    write_reg(rotenc_pkg::RegPosMax, hi);
    settings_used++;
    no_idle = steady;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        queue_word(rotenc_pkg::MODE_READ, 1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        if (pick < 80) begin
          // one gray step; direction changes rarely so the limits get reached
          if ($urandom_range(99) < 4) gen_dir = -gen_dir;
          gen_gray = (gen_gray + 4 + gen_dir) % 4;
          if ($urandom_range(99) < 8) gen_btn = ~gen_btn;
        end else if (pick < 90) begin
          if ($urandom_range(99) < 30) gen_btn = ~gen_btn;
        end else begin
          // contact bounce: arbitrary pin levels
          a = 1'($urandom);
          b = 1'($urandom);
          gen_btn  = 1'($urandom);
          gen_gray = a ? (b ? 2 : 1) : (b ? 3 : 0);
        end
        // gray order 00, 10, 11, 01 turns clockwise
        a = (gen_gray == 1) || (gen_gray == 2);
        b = (gen_gray == 2) || (gen_gray == 3);
        queue_word(rotenc_pkg::MODE_SCAN, gen_btn, a, b);
      end
    end
    wait_idle();
    no_idle = 1'b0;
  endtask

  initial begin
    scan_started = 1'b0;
    btn_armed    = 1'b1;
    a_prev       = 1'b0;
    pos_count    = rotenc_pkg::PosReset;
    pend_ev      = rotenc_pkg::EV_IDLE;
    lim_min      = rotenc_pkg::MinReset;
    lim_max      = rotenc_pkg::MaxReset;
    gen_gray     = 0;
    gen_dir      = 1;
    gen_btn      = 1'b1;
    no_idle      = 1'b0;
    cycle_count  = 0;
    mismatches   = 0;
    words_sent   = 0;
    results_seen = 0;
    settings_used = 1;
    foreach (ev_seen[k]) ev_seen[k] = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: read before any scan, then the first scan only latches a
    queue_word(rotenc_pkg::MODE_READ, 1'b0, 1'b1, 1'b1);
    queue_word(rotenc_pkg::MODE_SCAN, 1'b0, 1'b1, 1'b0);
    queue_word(rotenc_pkg::MODE_READ, 1'b1, 1'b0, 1'b0);
    // press, read it back, and a second read finds nothing pending
    queue_word(rotenc_pkg::MODE_SCAN, 1'b0, 1'b1, 1'b0);
    queue_word(rotenc_pkg::MODE_READ, 1'b0, 1'b0, 1'b0);
    queue_word(rotenc_pkg::MODE_READ, 1'b1, 1'b1, 1'b1);
    // release, then clockwise edge overwrites the unread release
    queue_word(rotenc_pkg::MODE_SCAN, 1'b1, 1'b1, 1'b1);
    queue_word(rotenc_pkg::MODE_SCAN, 1'b1, 1'b0, 1'b1);
    queue_word(rotenc_pkg::MODE_READ, 1'b0, 1'b1, 1'b0);
    // press and counter-clockwise edge in the same tick
    queue_word(rotenc_pkg::MODE_SCAN, 1'b0, 1'b1, 1'b1);
    queue_word(rotenc_pkg::MODE_READ, 1'b1, 1'b0, 1'b1);
    // still pressed, no edge: scan shows an idle event
    queue_word(rotenc_pkg::MODE_SCAN, 1'b0, 1'b1, 1'b1);
    queue_word(rotenc_pkg::MODE_SCAN, 1'b1, 1'b0, 1'b0);
    wait_idle();

    // position pinned: both limits equal to it, then min above max
    write_reg(rotenc_pkg::RegPosMin, pos_count);
    write_reg(rotenc_pkg::RegPosMax, pos_count);
    settings_used++;
    queue_word(rotenc_pkg::MODE_SCAN, 1'b1, 1'b1, 1'b0);
    queue_word(rotenc_pkg::MODE_SCAN, 1'b1, 1'b0, 1'b0);
    wait_idle();
    write_reg(rotenc_pkg::RegPosMin, 8'd255);
    write_reg(rotenc_pkg::RegPosMax, 8'd0);
    settings_used++;
    queue_word(rotenc_pkg::MODE_SCAN, 1'b1, 1'b1, 1'b0);
    queue_word(rotenc_pkg::MODE_SCAN, 1'b1, 1'b0, 1'b0);
    queue_word(rotenc_pkg::MODE_READ, 1'b0, 1'b1, 1'b1);
    wait_idle();

    // random phases, limits at the extremes and a few in between
    run_phase(8'd0,   8'd255, 115, 1'b0);
    run_phase(8'd18,  8'd24,  115, 1'b0);
    run_phase(8'd0,   8'd0,   115, 1'b1);
    run_phase(8'd255, 8'd255, 115, 1'b0);
    run_phase(8'd200, 8'd100, 115, 1'b0);
    run_phase(8'd5,   8'd8,   115, 1'b0);
    run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 115, 1'b0);
    run_phase(8'd0,   8'd3,   115, 1'b0);
    run_phase(8'($urandom_range(60)), 8'($urandom_range(255, 60)), 115, 1'b0);

    repeat (10) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("%0d words in, %0d results checked, %0d limit settings, %0d cycles",
             words_sent, results_seen, settings_used, cycle_count);
    $display("events: idle %0d push %0d release %0d cw %0d ccw %0d",
             ev_seen[0], ev_seen[1], ev_seen[2], ev_seen[3], ev_seen[4]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
